### src/trlc_pkg.sv
// ---------------------------------------------------------------------------
// trlc_pkg: shared types and constants
// Word types, scan modes, the command passed from scanner to emitter, and
// the base suffix lookup.
// ---------------------------------------------------------------------------
package trlc_pkg;

    localparam int LITERAL_CHARS = 32;
    localparam int DIG_AW = $clog2(LITERAL_CHARS);
    localparam int CNT_W = $clog2(LITERAL_CHARS + 1);
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    localparam logic [7:0] CH_GT = 8'h3e;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5a;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_PREFIX,
        MODE_BASEDIG,
        MODE_LITERAL
    } t_mode;

    // what the emitter has to do for one accepted input word
    typedef enum logic [1:0] {
        CMD_NONE,   // nothing is printed
        CMD_TEXT,   // prefix bytes then an optional plain byte
        CMD_NUMBER  // print the literal, then an optional plain byte
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [1:0]        npre;     // bytes of the directive prefix to echo
        logic              has_char; // echo ch at the end
        logic [7:0]        ch;
        logic [7:0]        base;
        logic [CNT_W-1:0]  int_end;
        logic [CNT_W-1:0]  count;
        logic              dot;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_input;
    } t_in_word;

    typedef enum logic [3:0] {
        E_IDLE,
        E_PRE,
        E_INT,
        E_FRAC_RD,
        E_FRAC_DIV,
        E_SCALE,
        E_SIGN,
        E_IDIG,
        E_FDIG,
        E_CHAR,
        E_WAIT
    } t_estate;

    function automatic logic [7:0] suffix_base(input logic [7:0] c);
        unique case (c)
            8'h62: suffix_base = 8'd2;
            8'h74: suffix_base = 8'd3;
            8'h71: suffix_base = 8'd4;
            8'h73: suffix_base = 8'd6;
            8'h6f: suffix_base = 8'd8;
            8'h69: suffix_base = 8'd10;
            8'h64: suffix_base = 8'd12;
            8'h78: suffix_base = 8'd16;
            8'h6d: suffix_base = 8'd32;
            default: suffix_base = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] i);
        unique case (i)
            2'd0: prefix_char = CH_GT;
            2'd1: prefix_char = CH_MINUS;
            default: prefix_char = CH_HASH;
        endcase
    endfunction

endpackage

### src/trlc_if.sv
// ---------------------------------------------------------------------------
// trlc_stream_if: valid/ready channel
// Carries one word of payload with a source and a sink side.
// ---------------------------------------------------------------------------
interface trlc_stream_if #(
    parameter int W = 9
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/trlc_ram.sv
// ---------------------------------------------------------------------------
// trlc_ram: generic single write, single read ram
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module trlc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/trlc_scan.sv
// ---------------------------------------------------------------------------
// trlc_scan: front end scanner
// Tracks directive and literal syntax, writes digits to the store and pushes
// one print command per word that produces text.
// ---------------------------------------------------------------------------
module trlc_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [7:0]                   i_char,
    input  logic                         i_eoi,
    output logic                         o_ready,
    // command queue push
    output logic                         o_push,
    output trlc_pkg::t_cmd               o_cmd,
    input  logic                         i_q_full,
    // store write port
    output logic                         o_we,
    output logic [trlc_pkg::DIG_AW-1:0]  o_waddr,
    output logic [5:0]                   o_wdata,
    // emitter still reads the store
    input  logic                         i_busy
);
    localparam int CW = trlc_pkg::CNT_W;

    trlc_pkg::t_mode   r_mode, n_mode;
    logic [1:0]        r_pm, n_pm;
    logic [7:0]        r_base, n_base;
    logic [7:0]        r_nb, n_nb;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_dot, n_dot;
    logic [CW-1:0]     r_dpos, n_dpos;

    logic is_dec, is_up, acc;
    logic [11:0] nb_w;
    logic [7:0]  sb;
    logic [CW:0] used;

    assign is_dec = i_char >= trlc_pkg::CH_ZERO && i_char <= trlc_pkg::CH_NINE;
    assign is_up = i_char >= trlc_pkg::CH_UA && i_char <= trlc_pkg::CH_UZ;
    assign sb = trlc_pkg::suffix_base(i_char);
    assign used = {1'b0, r_cnt} + {{CW{1'b0}}, r_dot};
    // a new literal would overwrite digits still being read
    assign o_ready = !i_q_full && !(r_mode == trlc_pkg::MODE_PLAIN && is_dec && i_busy);
    assign acc = i_valid && o_ready;
    assign nb_w = {4'd0, r_nb} * 12'd10 + {4'd0, i_char - trlc_pkg::CH_ZERO};

    always_comb begin
        n_mode = r_mode;
        n_pm = r_pm;
        n_base = r_base;
        n_nb = r_nb;
        n_cnt = r_cnt;
        n_dot = r_dot;
        n_dpos = r_dpos;
        o_push = 1'b0;
        o_cmd = '0;
        o_cmd.op = trlc_pkg::CMD_NONE;
        o_cmd.ch = i_char;
        o_cmd.base = r_base;
        o_cmd.count = r_cnt;
        o_cmd.dot = r_dot;
        o_cmd.int_end = r_dot ? r_dpos : r_cnt;
        o_we = 1'b0;
        o_waddr = r_cnt[trlc_pkg::DIG_AW-1:0];
        o_wdata = is_dec ? 6'(i_char - trlc_pkg::CH_ZERO) : 6'(i_char - trlc_pkg::CH_UA + 8'd10);
        if (acc) begin
            if (i_eoi) begin
                if (r_mode == trlc_pkg::MODE_LITERAL) begin
                    o_push = 1'b1;
                    o_cmd.op = trlc_pkg::CMD_NUMBER;
                end else if (r_mode == trlc_pkg::MODE_PREFIX) begin
                    o_push = 1'b1;
                    o_cmd.op = trlc_pkg::CMD_TEXT;
                    o_cmd.npre = r_pm;
                end
                n_mode = trlc_pkg::MODE_PLAIN;
                n_pm = '0;
            end else begin
                unique case (r_mode)
                    trlc_pkg::MODE_PREFIX: begin
                        if (r_pm != 2'd3 && i_char == trlc_pkg::prefix_char(r_pm)) begin
                            n_pm = r_pm + 2'd1;
                        end else begin
                            o_push = 1'b1;
                            o_cmd.op = trlc_pkg::CMD_TEXT;
                            o_cmd.npre = r_pm;
                            o_cmd.has_char = 1'b1;
                            n_pm = '0;
                            if (r_pm == 2'd3 && is_dec) begin
                                n_nb = i_char - trlc_pkg::CH_ZERO;
                                n_base = n_nb;
                                n_mode = trlc_pkg::MODE_BASEDIG;
                            end else begin
                                n_mode = trlc_pkg::MODE_PLAIN;
                            end
                        end
                    end
                    trlc_pkg::MODE_BASEDIG: begin
                        o_push = 1'b1;
                        o_cmd.op = trlc_pkg::CMD_TEXT;
                        o_cmd.has_char = 1'b1;
                        if (is_dec) begin
                            n_nb = nb_w > 12'd255 ? 8'd255 : nb_w[7:0];
                            n_base = n_nb;
                        end else begin
                            n_mode = trlc_pkg::MODE_PLAIN;
                        end
                    end
                    trlc_pkg::MODE_LITERAL: begin
                        if (is_dec || is_up) begin
                            if (used < (CW+1)'(trlc_pkg::LITERAL_CHARS - 1)) begin
                                o_we = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end else if (i_char == trlc_pkg::CH_DOT && !r_dot) begin
                            n_dot = 1'b1;
                            n_dpos = r_cnt;
                        end else begin
                            o_push = 1'b1;
                            o_cmd.op = trlc_pkg::CMD_NUMBER;
                            o_cmd.has_char = sb == 8'd0;
                            o_cmd.base = sb != 8'd0 ? sb : r_base;
                            n_mode = trlc_pkg::MODE_PLAIN;
                        end
                    end
                    default: begin
                        if (i_char == trlc_pkg::CH_GT) begin
                            n_mode = trlc_pkg::MODE_PREFIX;
                            n_pm = 2'd1;
                        end else if (is_dec) begin
                            o_we = 1'b1;
                            o_waddr = '0;
                            n_cnt = CW'(1);
                            n_dot = 1'b0;
                            n_dpos = '0;
                            n_mode = trlc_pkg::MODE_LITERAL;
                        end else begin
                            o_push = 1'b1;
                            o_cmd.op = trlc_pkg::CMD_TEXT;
                            o_cmd.has_char = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= trlc_pkg::MODE_PLAIN;
            r_pm <= '0;
            r_base <= 8'd10;
            r_nb <= '0;
            r_cnt <= '0;
            r_dot <= 1'b0;
            r_dpos <= '0;
        end else begin
            r_mode <= n_mode;
            r_pm <= n_pm;
            r_base <= n_base;
            r_nb <= n_nb;
            r_cnt <= n_cnt;
            r_dot <= n_dot;
            r_dpos <= n_dpos;
        end
    end

    // a dot may still arrive when the store is full
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full) else $error("push into full queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt} + {{CW{1'b0}}, r_dot} <= (CW+1)'(trlc_pkg::LITERAL_CHARS))
        else $error("literal overflow");
    a_dpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot |-> r_dpos <= r_cnt) else $error("dot past digits");
endmodule

### src/trlc_emit.sv
// ---------------------------------------------------------------------------
// trlc_emit: back end printer
// Pops commands, evaluates literals from the digit store with a serial
// divider and prints bytes into the output register.
// ---------------------------------------------------------------------------
module trlc_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  trlc_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output logic [trlc_pkg::DIG_AW-1:0]  o_raddr,
    input  logic [5:0]                   i_rdata,
    output logic                         o_busy,
    output logic                         o_valid,
    output trlc_pkg::t_out_word          o_word,
    input  logic                         i_ready
);
    localparam int CW = trlc_pkg::CNT_W;
    localparam int AW = trlc_pkg::DIG_AW;

    trlc_pkg::t_estate r_st, n_st;
    trlc_pkg::t_cmd    r_cmd, n_cmd;
    logic [CW-1:0]     r_i, n_i;
    logic [31:0]       r_v, n_v;
    logic [63:0]       r_acc, n_acc;
    logic [31:0]       r_rem, n_rem;   // running remainder of serial divide
    logic [5:0]        r_bit, n_bit;
    logic [31:0]       r_frac, n_frac;
    logic [31:0]       r_mag, n_mag;   // magnitude or fraction value to print
    logic [39:0]       r_digs, n_digs; // decimal digits, bcd, msd first
    logic [3:0]        r_nd, n_nd;
    logic              r_ov, n_ov;
    trlc_pkg::t_out_word r_ow, n_ow;
    logic              r_rd;           // read data valid for integer pass

    logic [2:0]  r_pc, n_pc;
    logic [39:0] prod;
    logic [32:0] trial;
    logic        out_free;
    logic        emit;
    logic [7:0]  emit_ch;
    logic        emit_last;
    logic [31:0] f6;

    assign out_free = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_word = r_ow;
    assign o_busy = r_st != trlc_pkg::E_IDLE;
    assign prod = {8'd0, r_v} * {32'd0, r_cmd.base};
    assign trial = {r_rem, r_acc[63]} - {25'd0, r_cmd.base};
    assign f6 = r_acc[63:32]; // frac * 10^6 >> 32 staged into r_acc

    always_comb begin
        n_st = r_st;
        n_cmd = r_cmd;
        n_i = r_i;
        n_v = r_v;
        n_acc = r_acc;
        n_rem = r_rem;
        n_bit = r_bit;
        n_frac = r_frac;
        n_mag = r_mag;
        n_digs = r_digs;
        n_nd = r_nd;
        n_pc = r_pc;
        o_pop = 1'b0;
        o_raddr = r_i[AW-1:0];
        emit = 1'b0;
        emit_ch = '0;
        emit_last = 1'b0;
        unique case (r_st)
            trlc_pkg::E_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_pc = '0;
                    n_i = '0;
                    n_v = '0;
                    n_frac = '0;
                    o_raddr = '0;
                    unique case (i_cmd.op)
                        trlc_pkg::CMD_NUMBER: n_st = trlc_pkg::E_INT;
                        trlc_pkg::CMD_TEXT: n_st = i_cmd.npre != 2'd0 ? trlc_pkg::E_PRE
                                                 : trlc_pkg::E_CHAR;
                        default: n_st = trlc_pkg::E_IDLE;
                    endcase
                end
            end
            trlc_pkg::E_PRE: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_ch = trlc_pkg::prefix_char(r_pc[1:0]);
                    emit_last = !r_cmd.has_char && r_pc[1:0] + 2'd1 == r_cmd.npre;
                    n_pc = r_pc + 3'd1;
                    if (r_pc[1:0] + 2'd1 == r_cmd.npre) begin
                        n_st = r_cmd.has_char ? trlc_pkg::E_CHAR : trlc_pkg::E_IDLE;
                    end
                end
            end
            trlc_pkg::E_INT: begin
                // data for address r_i arrives from the registered read in the cycle after it is presented
                if (r_rd && r_i != '0) begin
                    n_v = prod[31:0] + {26'd0, i_rdata};
                end
                if (r_i < r_cmd.int_end && !(r_rd && r_i != '0) ) begin
                    o_raddr = r_i[AW-1:0];
                    n_i = r_i + CW'(1);
                end else if (r_rd && r_i != '0 && r_i < r_cmd.int_end) begin
                    o_raddr = r_i[AW-1:0];
                    n_i = r_i + CW'(1);
                end else if (!(r_rd && r_i != '0)) begin
                    n_acc = '0;
                    n_i = r_cmd.count;
                    if (r_cmd.dot && r_cmd.base != 8'd0 && r_cmd.count > r_cmd.int_end) begin
                        o_raddr = AW'(r_cmd.count - CW'(1));
                        n_i = r_cmd.count - CW'(1);
                        n_st = trlc_pkg::E_FRAC_RD;
                    end else begin
                        n_st = trlc_pkg::E_SCALE;
                    end
                end
            end
            trlc_pkg::E_FRAC_RD: begin
                n_acc = {26'd0, i_rdata, 32'd0} + r_acc;
                n_rem = '0;
                n_bit = '0;
                n_st = trlc_pkg::E_FRAC_DIV;
            end
            trlc_pkg::E_FRAC_DIV: begin
                // restoring division, one quotient bit a cycle
                if (!trial[32]) begin
                    n_rem = trial[31:0];
                    n_acc = {r_acc[62:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_acc[63]};
                    n_acc = {r_acc[62:0], 1'b0};
                end
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'd63) begin
                    if (r_i > r_cmd.int_end) begin
                        o_raddr = AW'(r_i - CW'(1));
                        n_i = r_i - CW'(1);
                        n_st = trlc_pkg::E_FRAC_RD;
                    end else begin
                        n_st = trlc_pkg::E_SCALE;
                    end
                end
            end
            trlc_pkg::E_SCALE: begin
                n_v = r_v + r_acc[63:32];
                n_frac = r_acc[31:0];
                n_acc = {32'd0, r_acc[31:0]} * 64'd1000000;
                n_mag = (r_v + r_acc[63:32]);
                n_digs = '0;
                n_nd = '0;
                n_bit = '0;
                n_st = trlc_pkg::E_SIGN;
            end
            trlc_pkg::E_SIGN: begin
                // sign phase, then double dabble of the magnitude
                if (r_bit == 6'd0) begin
                    if (r_v[31]) begin
                        if (out_free) begin
                            emit = 1'b1;
                            emit_ch = trlc_pkg::CH_MINUS;
                            n_mag = 32'd0 - r_v;
                            n_bit = 6'd1;
                        end
                    end else begin
                        n_bit = 6'd1;
                    end
                end else begin
                    for (int k = 0; k < 10; k++) begin
                        n_digs[k*4 +: 4] = r_digs[k*4 +: 4] >= 4'd5 ?
                            r_digs[k*4 +: 4] + 4'd3 : r_digs[k*4 +: 4];
                    end
                    n_digs = {n_digs[38:0], r_mag[31]};
                    n_mag = {r_mag[30:0], 1'b0};
                    n_bit = r_bit + 6'd1;
                    if (r_bit == 6'd32) begin
                        n_nd = 4'd9;
                        n_st = trlc_pkg::E_IDIG;
                    end
                end
            end
            trlc_pkg::E_IDIG: begin
                // skip leading zeros, keep the last digit
                if (r_digs[39:36] == 4'd0 && r_nd != 4'd0) begin
                    n_digs = {r_digs[35:0], 4'd0};
                    n_nd = r_nd - 4'd1;
                end else if (out_free) begin
                    emit = 1'b1;
                    emit_ch = {4'h3, r_digs[39:36]};
                    emit_last = r_nd == 4'd0 && !r_cmd.dot && !r_cmd.has_char;
                    n_digs = {r_digs[35:0], 4'hf};
                    n_nd = r_nd - 4'd1;
                    if (r_nd == 4'd0) begin
                        n_pc = '0;
                        n_mag = f6;
                        n_st = r_cmd.dot ? trlc_pkg::E_FDIG
                             : (r_cmd.has_char ? trlc_pkg::E_CHAR : trlc_pkg::E_IDLE);
                        n_bit = '0;
                    end else begin
                        // force remaining digits to print
                        n_digs[39:36] = r_digs[35:32];
                        n_nd = r_nd - 4'd1;
                        n_st = trlc_pkg::E_WAIT;
                    end
                end
            end
            trlc_pkg::E_WAIT: begin
                // non-leading digit run
                if (out_free) begin
                    emit = 1'b1;
                    emit_ch = {4'h3, r_digs[39:36]};
                    emit_last = r_nd == 4'd0 && !r_cmd.dot && !r_cmd.has_char;
                    n_digs = {r_digs[35:0], 4'd0};
                    n_nd = r_nd - 4'd1;
                    if (r_nd == 4'd0) begin
                        n_mag = f6;
                        n_bit = '0;
                        n_st = r_cmd.dot ? trlc_pkg::E_FDIG
                             : (r_cmd.has_char ? trlc_pkg::E_CHAR : trlc_pkg::E_IDLE);
                    end
                end
            end
            trlc_pkg::E_FDIG: begin
                // bit 0 phase prints the dot, then dabble f6, then six digits
                if (r_bit == 6'd0) begin
                    if (out_free) begin
                        emit = 1'b1;
                        emit_ch = trlc_pkg::CH_DOT;
                        n_bit = 6'd1;
                        n_digs = '0;
                    end
                end else if (r_bit <= 6'd32) begin
                    for (int k = 0; k < 10; k++) begin
                        n_digs[k*4 +: 4] = r_digs[k*4 +: 4] >= 4'd5 ?
                            r_digs[k*4 +: 4] + 4'd3 : r_digs[k*4 +: 4];
                    end
                    n_digs = {n_digs[38:0], r_mag[31]};
                    n_mag = {r_mag[30:0], 1'b0};
                    n_bit = r_bit + 6'd1;
                    if (r_bit == 6'd32) begin
                        n_pc = '0;
                    end
                end else if (out_free) begin
                    emit = 1'b1;
                    emit_ch = {4'h3, r_digs[23:20]};
                    emit_last = r_pc == 3'd5 && !r_cmd.has_char;
                    n_digs = {r_digs[35:0], 4'd0};
                    n_pc = r_pc + 3'd1;
                    if (r_pc == 3'd5) begin
                        n_st = r_cmd.has_char ? trlc_pkg::E_CHAR : trlc_pkg::E_IDLE;
                    end
                end
            end
            trlc_pkg::E_CHAR: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_ch = r_cmd.ch;
                    emit_last = 1'b1;
                    n_st = trlc_pkg::E_IDLE;
                end
            end
            default: n_st = trlc_pkg::E_IDLE;
        endcase
        n_ov = emit ? 1'b1 : (i_ready ? 1'b0 : r_ov);
        n_ow = emit ? trlc_pkg::t_out_word'{out_char: emit_ch, last: emit_last} : r_ow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= trlc_pkg::E_IDLE;
            r_ov <= 1'b0;
            r_rd <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_rd <= (n_st == trlc_pkg::E_INT) && (n_i != r_i || r_st == trlc_pkg::E_IDLE)
                    && n_i != '0 || (r_st == trlc_pkg::E_IDLE && n_st == trlc_pkg::E_INT
                    && i_cmd.int_end != '0);
        end
        r_cmd <= n_cmd;
        r_i <= n_i;
        r_v <= n_v;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_frac <= n_frac;
        r_mag <= n_mag;
        r_digs <= n_digs;
        r_nd <= n_nd;
        r_pc <= n_pc;
        r_ow <= n_ow;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_ow)) else $error("output word lost");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == trlc_pkg::E_IDLE && i_q_valid) else $error("pop while busy");
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == trlc_pkg::E_IDLE |-> !emit) else $error("emit while idle");
endmodule

### src/trlc_queue.sv
// ---------------------------------------------------------------------------
// trlc_queue: command queue
// Short fifo of print commands between scanner and emitter.
// ---------------------------------------------------------------------------
module trlc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  trlc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output trlc_pkg::t_cmd o_cmd
);
    localparam int AW = trlc_pkg::QAW;

    trlc_pkg::t_cmd r_q [trlc_pkg::QDEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_n;

    assign o_full = r_n == (AW+1)'(trlc_pkg::QDEPTH);
    assign o_valid = r_n != '0;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop) r_rp <= r_rp + AW'(1);
            r_n <= r_n + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) r_q[r_wp] <= i_cmd;
    end
endmodule

### src/text_radix_literal_converter.sv
// ---------------------------------------------------------------------------
// text_radix_literal_converter: radix literal rewriting text filter
// Copies text through, rewriting numeric literals in decimal.
// ---------------------------------------------------------------------------
// usage
//   s_in carries {in_char, end_of_input}, m_out carries {out_char, last};
//   a word moves when valid and ready are high at a rising edge
//   a plain byte is pushed into the command queue, popped by the emitter
//   and printed into the output register; the emitter pops a command only
//   when idle, so each command's bytes are printed before the next pop
//   literal bytes are written to the digit store as they are taken; the
//   terminating byte starts the emitter: an integer pass over the digits,
//   then the serial divider for each fraction digit, binary to bcd,
//   skipping of leading zeros and printing of bytes, and binary to bcd
//   once more for the fraction
//   the scanner keeps accepting while the command queue has room, except
//   a new literal waits until the queue is empty and the emitter is idle
//   reset clears modes, sets the base to ten and empties queue and output
//   a stalled receiver holds the output register; the emitter and then the
//   queue fill, and finally s_in.ready drops
// ---------------------------------------------------------------------------
module text_radix_literal_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    trlc_stream_if.sink           s_in,
    trlc_stream_if.source         m_out
);
    trlc_pkg::t_in_word in_w;
    trlc_pkg::t_cmd push_cmd, q_cmd;
    trlc_pkg::t_out_word ow;
    logic push, q_full, pop, q_valid, we, busy, ready;
    logic [trlc_pkg::DIG_AW-1:0] waddr, raddr;
    logic [5:0] wdata, rdata;

    assign in_w = s_in.data;
    assign s_in.ready = ready;
    assign m_out.data = ow;

    // a queued number command still needs the store as well
    trlc_scan u_scan (
        .i_clk, .i_rst_n,
        .i_valid(s_in.valid), .i_char(in_w.in_char), .i_eoi(in_w.end_of_input),
        .o_ready(ready), .o_push(push), .o_cmd(push_cmd), .i_q_full(q_full),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .i_busy(busy || q_valid)
    );

    trlc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(push_cmd), .o_full(q_full),
        .i_pop(pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    trlc_ram #(.WIDTH(6), .DEPTH(trlc_pkg::LITERAL_CHARS)) u_store (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    trlc_emit u_emit (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_raddr(raddr), .i_rdata(rdata), .o_busy(busy),
        .o_valid(m_out.valid), .o_word(ow), .i_ready(m_out.ready)
    );
endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: text radix literal converter
// Sends a short directed text through the converter, then random text built
// from directives, literals and noise. Every output word is compared with the
// text of its directed row or with a software copy of scanner and printer.
// ---------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 40000;

    logic i_clk;
    logic i_rst_n;

    trlc_stream_if #(.W(9)) s_in ();
    trlc_stream_if #(.W(9)) m_out ();

    text_radix_literal_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // one row of the directed text; typed rows carry the output text itself
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         typed;
        string      want;
    } t_row;

    t_row directed_rows[$];
    trlc_pkg::t_out_word expected_text[$];
    trlc_pkg::t_out_word step_text[$];

    // shadow of the scanner state
    trlc_pkg::t_mode sh_mode;
    int unsigned sh_matched;
    int unsigned sh_base;
    int unsigned sh_new_base;
    logic [5:0] sh_digits[trlc_pkg::LITERAL_CHARS];
    int unsigned sh_count;
    bit         sh_dot;
    int unsigned sh_dot_pos;

    int errors;
    int words_sent;
    int words_checked;
    int literals_sent;
    int directives_sent;
    int idle_cycles;
    int burst_left;
    bit stimulus_done;

    function automatic bit is_dec(logic [7:0] c);
        return c >= trlc_pkg::CH_ZERO && c <= trlc_pkg::CH_NINE;
    endfunction

    function automatic int unsigned base_of_suffix(logic [7:0] c);
        case (c)
            "b": return 2;
            "t": return 3;
            "q": return 4;
            "s": return 6;
            "o": return 8;
            "i": return 10;
            "d": return 12;
            "x": return 16;
            "m": return 32;
            default: return 0;
        endcase
    endfunction

    function automatic void put_char(logic [7:0] c);
        trlc_pkg::t_out_word w;
        w.out_char = c;
        w.last = 1'b0;
        step_text.push_back(w);
    endfunction

    function automatic void put_prefix(int unsigned n);
        for (int unsigned i = 0; i < n && i < 3; i++)
            put_char(i == 0 ? trlc_pkg::CH_GT
                     : (i == 1 ? trlc_pkg::CH_MINUS : trlc_pkg::CH_HASH));
    endfunction

    // signed integer part, then the six fraction places when a dot was seen
    function automatic void print_number(int unsigned base);
        int unsigned int_end;
        logic [31:0] v;
        logic [31:0] frac;
        logic [31:0] mag;
        logic [63:0] acc;
        logic [63:0] f6;
        logic [7:0]  rev[$];
        int unsigned dv;
        int_end = sh_dot ? sh_dot_pos : sh_count;
        if (int_end > sh_count) int_end = sh_count;
        v = '0;
        frac = '0;
        for (int unsigned i = 0; i < int_end; i++)
            v = v * base + 32'(sh_digits[i]);
        if (sh_dot && base != 0) begin
            acc = '0;
            for (int i = int'(sh_count) - 1; i >= int'(int_end); i--)
                acc = ((64'(sh_digits[i]) << 32) + acc) / 64'(base);
            v = v + acc[63:32];
            frac = acc[31:0];
        end
        if (v[31]) begin
            put_char("-");
            mag = -v;
        end else begin
            mag = v;
        end
        do begin
            rev.push_front(8'(trlc_pkg::CH_ZERO + mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (rev[i]) put_char(rev[i]);
        if (sh_dot) begin
            f6 = (64'(frac) * 64'd1000000) >> 32;
            put_char(trlc_pkg::CH_DOT);
            dv = 100000;
            while (dv != 0) begin
                put_char(8'(trlc_pkg::CH_ZERO + (f6 / dv) % 10));
                dv = dv / 10;
            end
        end
    endfunction

    // advance the shadow by one word; the printed bytes land in step_text
    function automatic void scan_word(logic [7:0] c, logic eoi);
        int unsigned nb;
        int unsigned sb;
        step_text.delete();
        if (eoi) begin
            if (sh_mode == trlc_pkg::MODE_LITERAL) print_number(sh_base);
            else if (sh_mode == trlc_pkg::MODE_PREFIX) put_prefix(sh_matched);
            sh_mode = trlc_pkg::MODE_PLAIN;
            sh_matched = 0;
        end else if (sh_mode == trlc_pkg::MODE_PREFIX) begin
            if (sh_matched < 3 && c == trlc_pkg::prefix_char(2'(sh_matched))) begin
                sh_matched++;
            end else if (sh_matched >= 3 && is_dec(c)) begin
                put_prefix(3);
                put_char(c);
                sh_new_base = c - trlc_pkg::CH_ZERO;
                sh_base = sh_new_base;
                sh_mode = trlc_pkg::MODE_BASEDIG;
                sh_matched = 0;
            end else begin
                // broken prefix: what matched, then the byte itself
                put_prefix(sh_matched);
                put_char(c);
                sh_mode = trlc_pkg::MODE_PLAIN;
                sh_matched = 0;
            end
        end else if (sh_mode == trlc_pkg::MODE_BASEDIG) begin
            put_char(c);
            if (is_dec(c)) begin
                nb = sh_new_base * 10 + (c - trlc_pkg::CH_ZERO);
                sh_new_base = nb > 255 ? 255 : nb;
                sh_base = sh_new_base;
            end else begin
                sh_mode = trlc_pkg::MODE_PLAIN;
            end
        end else if (sh_mode == trlc_pkg::MODE_LITERAL) begin
            if (is_dec(c) || (c >= trlc_pkg::CH_UA && c <= trlc_pkg::CH_UZ)) begin
                // long literal: extra characters are dropped
                if (sh_count + sh_dot < trlc_pkg::LITERAL_CHARS - 1
                        && sh_count < trlc_pkg::LITERAL_CHARS) begin
                    sh_digits[sh_count] = is_dec(c) ? 6'(c - trlc_pkg::CH_ZERO)
                                                    : 6'(c - trlc_pkg::CH_UA + 10);
                    sh_count++;
                end
            end else if (c == trlc_pkg::CH_DOT && !sh_dot) begin
                sh_dot = 1'b1;
                sh_dot_pos = sh_count;
            end else begin
                sb = base_of_suffix(c);
                print_number(sb != 0 ? sb : sh_base);
                if (sb == 0) put_char(c);
                sh_mode = trlc_pkg::MODE_PLAIN;
            end
        end else begin
            if (c == trlc_pkg::CH_GT) begin
                sh_mode = trlc_pkg::MODE_PREFIX;
                sh_matched = 1;
            end else if (is_dec(c)) begin
                sh_digits[0] = 6'(c - trlc_pkg::CH_ZERO);
                sh_count = 1;
                sh_dot = 1'b0;
                sh_dot_pos = 0;
                sh_mode = trlc_pkg::MODE_LITERAL;
            end else begin
                put_char(c);
            end
        end
        if (step_text.size() > 0) step_text[step_text.size() - 1].last = 1'b1;
    endfunction

    // drive one input word in bursts with random gaps between them
    task automatic send_word(logic [7:0] c, logic eoi, bit typed, string want);
        trlc_pkg::t_in_word w;
        trlc_pkg::t_out_word o;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        w.in_char = c;
        w.end_of_input = eoi;
        s_in.valid <= 1'b1;
        s_in.data <= w;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        words_sent++;
        scan_word(c, eoi);
        if (typed) begin
            // directed rows carry their output text; the shadow still advances
            for (int i = 0; i < want.len(); i++) begin
                o.out_char = want[i];
                o.last = (i == want.len() - 1);
                expected_text.push_back(o);
            end
        end else begin
            foreach (step_text[i]) expected_text.push_back(step_text[i]);
        end
    endtask

    task automatic send_char(logic [7:0] c);
        send_word(c, 1'b0, 1'b0, "");
    endtask

    function automatic logic [7:0] literal_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'(trlc_pkg::CH_ZERO + $urandom_range(0, 9));
            4, 5, 6: return 8'(trlc_pkg::CH_UA + $urandom_range(0, 25));
            7: return trlc_pkg::CH_DOT;
            default: return 8'(trlc_pkg::CH_ZERO + $urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_literal();
        int len;
        string suffixes;
        suffixes = "btqsoidxm";
        len = $urandom_range(0, 9) == 0 ? $urandom_range(28, 40) : $urandom_range(0, 8);
        literals_sent++;
        send_char(8'(trlc_pkg::CH_ZERO + $urandom_range(0, 9)));
        repeat (len) send_char(literal_char());
        case ($urandom_range(0, 3))
            0, 1: send_char(suffixes[$urandom_range(0, 8)]);
            2: send_word(8'h00, 1'b1, 1'b0, "");
            default: send_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_directive();
        int ndig;
        directives_sent++;
        send_char(trlc_pkg::CH_GT);
        send_char(trlc_pkg::CH_MINUS);
        send_char(trlc_pkg::CH_HASH);
        case ($urandom_range(0, 5))
            0: begin
                // base zero, one or two
                send_char(8'(trlc_pkg::CH_ZERO + $urandom_range(0, 2)));
            end
            1: begin
                // value that can saturate
                repeat ($urandom_range(3, 4))
                    send_char(8'(trlc_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            default: begin
                ndig = $urandom_range(1, 2);
                if (ndig == 1) begin
                    send_char(8'(trlc_pkg::CH_ZERO + $urandom_range(2, 9)));
                end else begin
                    send_char(8'(trlc_pkg::CH_ZERO + $urandom_range(1, 3)));
                    send_char(8'(trlc_pkg::CH_ZERO + $urandom_range(0, 6)));
                end
            end
        endcase
        if ($urandom_range(0, 5) == 0) send_word(8'h00, 1'b1, 1'b0, "");
        else send_char(8'($urandom_range(32, 126)) & ~8'h10 | 8'h40);
    endtask

    task automatic send_noise();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            send_char(8'($urandom_range(0, 255)));
        end else if (k < 8) begin
            // broken prefix
            send_char(trlc_pkg::CH_GT);
            if ($urandom_range(0, 1)) send_char(trlc_pkg::CH_MINUS);
            send_char(8'($urandom_range(0, 255)));
        end else begin
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, "");
        end
    endtask

    // output side: stall pattern and comparison
    int stall_phase;
    int cycle_count;
    always @(posedge i_clk) begin
        trlc_pkg::t_out_word got;
        trlc_pkg::t_out_word want;
        if (!i_rst_n) begin
            m_out.ready <= 1'b0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            stall_phase = (cycle_count / 300) % 4;
            case (stall_phase)
                0: m_out.ready <= 1'b1;
                1: m_out.ready <= ($urandom_range(0, 3) != 0);
                2: m_out.ready <= (cycle_count % 7) < 2;
                default: m_out.ready <= ($urandom_range(0, 1) == 1);
            endcase
            if (m_out.valid && m_out.ready) begin
                got = m_out.data;
                words_checked++;
                if (expected_text.size() == 0) begin
                    $error("unexpected output word %h", got);
                    errors++;
                end else begin
                    want = expected_text.pop_front();
                    if (got.out_char !== want.out_char) begin
                        $error("out_char expected %h actual %h", want.out_char, got.out_char);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last expected %b actual %b", want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_in.valid && s_in.ready) || (m_out.valid && m_out.ready)) begin
            idle_cycles <= 0;
        end else if (!stimulus_done || expected_text.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d words outstanding", expected_text.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic add_row(logic [7:0] c, logic eoi, string want);
        t_row r;
        r.ch = c;
        r.eoi = eoi;
        r.typed = 1'b1;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    initial begin
        int r;
        bit drained;
        i_rst_n = 1'b0;
        s_in.valid = 1'b0;
        s_in.data = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        literals_sent = 0;
        directives_sent = 0;
        burst_left = 0;
        drained = 1'b0;
        stimulus_done = 1'b0;
        sh_mode = trlc_pkg::MODE_PLAIN;
        sh_matched = 0;
        sh_base = 10;
        sh_new_base = 0;
        sh_count = 0;
        sh_dot = 1'b0;
        sh_dot_pos = 0;

        // plain byte, decimal literal, hex suffix with fraction
        add_row("A", 1'b0, "A");
        add_row("7", 1'b0, "");
        add_row(" ", 1'b0, "7 ");
        add_row("1", 1'b0, "");
        add_row(".", 1'b0, "");
        add_row("8", 1'b0, "");
        add_row("x", 1'b0, "1.500000");
        // directive to base two, then a broken prefix
        add_row(">", 1'b0, "");
        add_row("-", 1'b0, "");
        add_row("#", 1'b0, "");
        add_row("2", 1'b0, ">-#2");
        add_row("a", 1'b0, "a");
        add_row(">", 1'b0, "");
        add_row("-", 1'b0, "");
        add_row("X", 1'b0, ">-X");
        add_row(8'hff, 1'b1, "");
        // second dot ends the literal and is echoed
        add_row("9", 1'b0, "");
        add_row("9", 1'b0, "");
        add_row(".", 1'b0, "");
        add_row(".", 1'b0, "27.000000.");
        // pending prefix flushed by end of input
        add_row(">", 1'b0, "");
        add_row(8'h00, 1'b1, ">");

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].ch, directed_rows[i].eoi,
                      directed_rows[i].typed, directed_rows[i].want);

        while (words_sent < 265) begin
            r = $urandom_range(0, 9);
            if (r < 5) send_literal();
            else if (r < 7) send_directive();
            else send_noise();
            if (!drained && words_sent > 150) begin
                // hold off until the converter has drained
                s_in.valid <= 1'b0;
                burst_left = 0;
                @(posedge i_clk);
                while (expected_text.size() != 0) @(posedge i_clk);
                repeat (50) @(posedge i_clk);
                drained = 1'b1;
            end
        end
        s_in.valid <= 1'b0;
        stimulus_done = 1'b1;
        @(posedge i_clk);
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);

        $display("sent %0d input words (%0d literals, %0d directives), checked %0d output words",
                 words_sent, literals_sent, directives_sent, words_checked);
        if (errors == 0 && expected_text.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
src/trlc_pkg.sv
src/trlc_if.sv
src/trlc_ram.sv
src/trlc_scan.sv
src/trlc_emit.sv
src/trlc_queue.sv
src/text_radix_literal_converter.sv
bench/testbench.sv
